[hdl/tcq_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and defaults for the two-class drop-policy queue
package tcq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int CFG_BITS    = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CAP_BITS    = 7;
    localparam int SEL_BITS    = 3;
    localparam int CNT_BITS    = 32;
    localparam int CNT_NUM     = 6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DROP_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRUCT_RES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CNT_SELECT  = 2'd3;

    localparam logic                RST_DROP_POLICY = 1'b0;
    localparam logic [CAP_BITS-1:0] RST_SAMPLE_CAP  = 7'd48;
    localparam logic [CAP_BITS-1:0] RST_STRUCT_RES  = 7'd16;
    localparam logic [SEL_BITS-1:0] RST_CNT_SELECT  = 3'd0;

    // operation codes
    localparam logic [1:0] FUNC_OFFER = 2'd0;
    localparam logic [1:0] FUNC_DRAIN = 2'd1;
    localparam logic [1:0] FUNC_CLOSE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_REC   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // event counter indexes
    localparam logic [SEL_BITS-1:0] CNT_SAMP_OFF  = 3'd0;
    localparam logic [SEL_BITS-1:0] CNT_STRU_OFF  = 3'd1;
    localparam logic [SEL_BITS-1:0] CNT_SAMP_DROP = 3'd2;
    localparam logic [SEL_BITS-1:0] CNT_STRU_DROP = 3'd3;
    localparam logic [SEL_BITS-1:0] CNT_SAMP_LATE = 3'd4;
    localparam logic [SEL_BITS-1:0] CNT_STRU_LATE = 3'd5;

    typedef struct packed {
        logic                en;
        logic [SEL_BITS-1:0] idx;
    } tcq_bump_t;

endpackage

[hdl/tcq_store.sv]
`timescale 1ns / 1ps
// record store: one write port, one registered read port
module tcq_store #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tcq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
    input  logic [PAYLOAD_BITS:0]         wdata,
    input  logic                          re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
    output logic [PAYLOAD_BITS:0]         rdata
);

    logic [PAYLOAD_BITS:0] mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/tcq_counters.sv]
`timescale 1ns / 1ps
// saturating event counters with the selected counter shown
module tcq_counters (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcq_pkg::tcq_bump_t                bump,
    input  logic [tcq_pkg::SEL_BITS-1:0]      counter_select,
    output logic [tcq_pkg::CNT_BITS-1:0]      counter_value
);

    logic [tcq_pkg::CNT_BITS-1:0] cnt_reg [tcq_pkg::CNT_NUM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcq_pkg::CNT_NUM; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (bump.en && (bump.idx < tcq_pkg::SEL_BITS'(tcq_pkg::CNT_NUM)))
        begin
            if (cnt_reg[bump.idx] != '1)
            begin
                cnt_reg[bump.idx] <= cnt_reg[bump.idx] + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (counter_select < tcq_pkg::SEL_BITS'(tcq_pkg::CNT_NUM))
        begin
            counter_value = cnt_reg[counter_select];
        end
        else
        begin
            counter_value = '0;
        end
    end

endmodule

[hdl/tcq_ctrl.sv]
`timescale 1ns / 1ps
// sequencer: admission, eviction scan, compaction, drain and result register
module tcq_ctrl #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tcq_pkg::PAYLOAD_BITS_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic                              is_structural,
    input  logic [PAYLOAD_BITS-1:0]           payload,
    input  logic                              drop_policy,
    input  logic [tcq_pkg::CAP_BITS-1:0]      sample_capacity,
    input  logic [tcq_pkg::CAP_BITS-1:0]      structural_reserve,
    output logic                              mem_we,
    output logic [IDX_W-1:0]                  mem_waddr,
    output logic [PAYLOAD_BITS:0]             mem_wdata,
    output logic                              mem_re,
    output logic [IDX_W-1:0]                  mem_raddr,
    input  logic [PAYLOAD_BITS:0]             mem_rdata,
    output tcq_pkg::tcq_bump_t                bump,
    input  logic [tcq_pkg::CNT_BITS-1:0]      counter_value_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        result_kind,
    output logic                              record_structural,
    output logic [PAYLOAD_BITS-1:0]           record_payload,
    output logic                              last,
    output logic                              accepted,
    output logic                              evicted_sample,
    output logic                              is_closed,
    output logic [CNT_W-1:0]                  occupancy,
    output logic [CNT_W-1:0]                  high_water,
    output logic [tcq_pkg::CNT_BITS-1:0]      counter_value
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_DROP      = 4'd2;
    localparam logic [3:0] S_SCAN_RD   = 4'd3;
    localparam logic [3:0] S_SCAN_CHK  = 4'd4;
    localparam logic [3:0] S_SHIFT_RD  = 4'd5;
    localparam logic [3:0] S_SHIFT_WR  = 4'd6;
    localparam logic [3:0] S_APPEND    = 4'd7;
    localparam logic [3:0] S_RESP      = 4'd8;
    localparam logic [3:0] S_DRAIN_RD  = 4'd9;
    localparam logic [3:0] S_DRAIN_OUT = 4'd10;

    localparam int LW = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [LW-1:0]    DEPTH_L = LW'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [3:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        peak_reg, peak_next;
    logic                    closed_reg, closed_next;
    logic                    evict_reg, evict_next;
    logic                    acc_reg, acc_next;
    logic [1:0]              kind_reg, kind_next;
    logic [1:0]              func_reg, func_next;
    logic                    cls_reg, cls_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;

    logic                    ov_reg, ov_next;
    logic [1:0]              o_kind_reg, o_kind_next;
    logic                    o_cls_reg, o_cls_next;
    logic [PAYLOAD_BITS-1:0] o_pay_reg, o_pay_next;
    logic                    o_last_reg, o_last_next;
    logic                    o_acc_reg, o_acc_next;
    logic                    o_ev_reg, o_ev_next;
    logic                    o_closed_reg, o_closed_next;
    logic [CNT_W-1:0]        o_occ_reg, o_occ_next;
    logic [CNT_W-1:0]        o_hw_reg, o_hw_next;
    logic [tcq_pkg::CNT_BITS-1:0] o_cv_reg, o_cv_next;

    logic             out_free;
    logic [CNT_W-1:0] idx_inc;
    logic [LW-1:0]    lim_raw, limit;
    logic             over;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !ov_reg || !out_stall;
    assign idx_inc  = CNT_W'(idx_reg) + 1'b1;

    // admission limit, clamped to the depth
    always_comb
    begin
        if (cls_reg)
        begin
            lim_raw = LW'(sample_capacity) + LW'(structural_reserve);
        end
        else
        begin
            lim_raw = LW'(sample_capacity);
        end
        limit = (lim_raw > DEPTH_L) ? DEPTH_L : lim_raw;
        over  = (LW'(count_reg) >= limit);
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        peak_next     = peak_reg;
        closed_next   = closed_reg;
        evict_next    = evict_reg;
        acc_next      = acc_reg;
        kind_next     = kind_reg;
        func_next     = func_reg;
        cls_next      = cls_reg;
        pay_next      = pay_reg;
        ov_next       = ov_reg && out_stall;
        o_kind_next   = o_kind_reg;
        o_cls_next    = o_cls_reg;
        o_pay_next    = o_pay_reg;
        o_last_next   = o_last_reg;
        o_acc_next    = o_acc_reg;
        o_ev_next     = o_ev_reg;
        o_closed_next = o_closed_reg;
        o_occ_next    = o_occ_reg;
        o_hw_next     = o_hw_reg;
        o_cv_next     = o_cv_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = mem_rdata;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg;
        bump.en       = 1'b0;
        bump.idx      = tcq_pkg::CNT_SAMP_OFF;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    cls_next   = is_structural;
                    pay_next   = payload;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                evict_next = 1'b0;
                acc_next   = 1'b0;
                kind_next  = tcq_pkg::KIND_ACK;
                case (func_reg)
                    tcq_pkg::FUNC_OFFER:
                    begin
                        bump.en = 1'b1;
                        if (closed_reg)
                        begin
                            bump.idx   = cls_reg ? tcq_pkg::CNT_STRU_LATE
                                                 : tcq_pkg::CNT_SAMP_LATE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            bump.idx = cls_reg ? tcq_pkg::CNT_STRU_OFF
                                               : tcq_pkg::CNT_SAMP_OFF;
                            idx_next = '0;
                            if (!over)
                            begin
                                state_next = S_APPEND;
                            end
                            else if (!drop_policy || (count_reg == '0))
                            begin
                                state_next = S_DROP;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                    end
                    tcq_pkg::FUNC_DRAIN:
                    begin
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            kind_next  = tcq_pkg::KIND_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_DRAIN_RD;
                        end
                    end
                    tcq_pkg::FUNC_CLOSE:
                    begin
                        closed_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DROP:
            begin
                bump.en    = 1'b1;
                bump.idx   = cls_reg ? tcq_pkg::CNT_STRU_DROP : tcq_pkg::CNT_SAMP_DROP;
                state_next = S_RESP;
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                bump.en = 1'b1;
                if (!mem_rdata[PAYLOAD_BITS])
                begin
                    // oldest sample found, evict it
                    bump.idx   = tcq_pkg::CNT_SAMP_DROP;
                    state_next = S_SHIFT_RD;
                end
                else if (idx_inc >= count_reg)
                begin
                    // only structural records queued, refuse arrival
                    bump.idx   = cls_reg ? tcq_pkg::CNT_STRU_DROP : tcq_pkg::CNT_SAMP_DROP;
                    state_next = S_RESP;
                end
                else
                begin
                    bump.en    = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    evict_next = 1'b1;
                    state_next = S_APPEND;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg + 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_APPEND:
            begin
                if (count_reg < DEPTH_C)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IDX_W-1:0];
                    mem_wdata  = {cls_reg, pay_reg};
                    count_next = count_reg + 1'b1;
                    if (count_next > peak_reg)
                    begin
                        peak_next = count_next;
                    end
                end
                acc_next   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_kind_next   = kind_reg;
                    o_cls_next    = 1'b0;
                    o_pay_next    = '0;
                    o_last_next   = 1'b1;
                    o_acc_next    = acc_reg;
                    o_ev_next     = evict_reg;
                    o_closed_next = closed_reg;
                    o_occ_next    = count_reg;
                    o_hw_next     = peak_reg;
                    o_cv_next     = counter_value_in;
                    state_next    = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_DRAIN_OUT;
            end
            S_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_kind_next   = tcq_pkg::KIND_REC;
                    o_cls_next    = mem_rdata[PAYLOAD_BITS];
                    o_pay_next    = mem_rdata[PAYLOAD_BITS-1:0];
                    o_last_next   = (idx_inc == count_reg);
                    o_acc_next    = 1'b0;
                    o_ev_next     = 1'b0;
                    o_closed_next = closed_reg;
                    o_occ_next    = '0;
                    o_hw_next     = peak_reg;
                    o_cv_next     = counter_value_in;
                    if (idx_inc == count_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            peak_reg   <= '0;
            closed_reg <= 1'b0;
            evict_reg  <= 1'b0;
            acc_reg    <= 1'b0;
            kind_reg   <= tcq_pkg::KIND_ACK;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            peak_reg   <= peak_next;
            closed_reg <= closed_next;
            evict_reg  <= evict_next;
            acc_reg    <= acc_next;
            kind_reg   <= kind_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        cls_reg      <= cls_next;
        pay_reg      <= pay_next;
        o_kind_reg   <= o_kind_next;
        o_cls_reg    <= o_cls_next;
        o_pay_reg    <= o_pay_next;
        o_last_reg   <= o_last_next;
        o_acc_reg    <= o_acc_next;
        o_ev_reg     <= o_ev_next;
        o_closed_reg <= o_closed_next;
        o_occ_reg    <= o_occ_next;
        o_hw_reg     <= o_hw_next;
        o_cv_reg     <= o_cv_next;
    end

    assign out_valid         = ov_reg;
    assign result_kind       = o_kind_reg;
    assign record_structural = o_cls_reg;
    assign record_payload    = o_pay_reg;
    assign last              = o_last_reg;
    assign accepted          = o_acc_reg;
    assign evicted_sample    = o_ev_reg;
    assign is_closed         = o_closed_reg;
    assign occupancy         = o_occ_reg;
    assign high_water        = o_hw_reg;
    assign counter_value     = o_cv_reg;

endmodule

[hdl/two_class_drop_policy_queue_core.sv]
`timescale 1ns / 1ps
// top level of the two-class drop-policy record queue
//
// input channel (in_valid/in_stall) carries one operation per transfer: offer a
// record, drain all records, or close. in_stall is high while an operation is
// being worked on; a new operation is taken as soon as the sequencer is back in
// idle, even if the last result still sits in the output register.
// output channel (out_valid/out_stall) carries results from one output register.
// an offer gives one acknowledge; a drain gives every queued record in arrival
// order with last on the final one, or one empty-drain result; close gives none.
// sequence: a plain offer passes through decide, append and the result register, and
// the next operation can be taken once its result is in that register. with drop-oldest
// on a full queue an eviction first reads and checks each record up to the oldest sample,
// then moves each record behind it up one place by a read and a write; a scan that finds
// no sample reads and checks every queued record. the single read and single write port
// of the record store make these steps serial. a drain reads each record and hands it to
// the output register before it reads the next one.
// a stall on the output holds the result and pauses any drain in progress.
// reset clears occupancy, closed flag, high-water mark and counters and loads the
// register defaults; the record store needs no clearing pass.
// configuration writes (cfg_we/cfg_index/cfg_data) take effect on the next edge.
module two_class_drop_policy_queue_core #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tcq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            func,
    input  logic                                  is_structural,
    input  logic [PAYLOAD_BITS-1:0]               payload,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            result_kind,
    output logic                                  record_structural,
    output logic [PAYLOAD_BITS-1:0]               record_payload,
    output logic                                  last,
    output logic                                  accepted,
    output logic                                  evicted_sample,
    output logic                                  is_closed,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      occupancy,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      high_water,
    output logic [tcq_pkg::CNT_BITS-1:0]          counter_value,
    input  logic                                  cfg_we,
    input  logic [tcq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tcq_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic                           drop_policy_reg;
    logic [tcq_pkg::CAP_BITS-1:0]   sample_cap_reg;
    logic [tcq_pkg::CAP_BITS-1:0]   struct_res_reg;
    logic [tcq_pkg::SEL_BITS-1:0]   cnt_sel_reg;

    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [PAYLOAD_BITS:0]          mem_wdata;
    logic                           mem_re;
    logic [IDX_W-1:0]               mem_raddr;
    logic [PAYLOAD_BITS:0]          mem_rdata;
    tcq_pkg::tcq_bump_t             bump;
    logic [tcq_pkg::CNT_BITS-1:0]   cnt_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_policy_reg <= tcq_pkg::RST_DROP_POLICY;
            sample_cap_reg  <= tcq_pkg::RST_SAMPLE_CAP;
            struct_res_reg  <= tcq_pkg::RST_STRUCT_RES;
            cnt_sel_reg     <= tcq_pkg::RST_CNT_SELECT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcq_pkg::REG_DROP_POLICY: drop_policy_reg <= cfg_data[0];
                tcq_pkg::REG_SAMPLE_CAP:  sample_cap_reg  <= cfg_data[tcq_pkg::CAP_BITS-1:0];
                tcq_pkg::REG_STRUCT_RES:  struct_res_reg  <= cfg_data[tcq_pkg::CAP_BITS-1:0];
                tcq_pkg::REG_CNT_SELECT:  cnt_sel_reg     <= cfg_data[tcq_pkg::SEL_BITS-1:0];
                default:                  cnt_sel_reg     <= cnt_sel_reg;
            endcase
        end
    end

    tcq_store #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcq_counters u_counters (
        .clk            (clk),
        .rst_n          (rst_n),
        .bump           (bump),
        .counter_select (cnt_sel_reg),
        .counter_value  (cnt_value)
    );

    tcq_ctrl #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .func               (func),
        .is_structural      (is_structural),
        .payload            (payload),
        .drop_policy        (drop_policy_reg),
        .sample_capacity    (sample_cap_reg),
        .structural_reserve (struct_res_reg),
        .mem_we             (mem_we),
        .mem_waddr          (mem_waddr),
        .mem_wdata          (mem_wdata),
        .mem_re             (mem_re),
        .mem_raddr          (mem_raddr),
        .mem_rdata          (mem_rdata),
        .bump               (bump),
        .counter_value_in   (cnt_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .result_kind        (result_kind),
        .record_structural  (record_structural),
        .record_payload     (record_payload),
        .last               (last),
        .accepted           (accepted),
        .evicted_sample     (evicted_sample),
        .is_closed          (is_closed),
        .occupancy          (occupancy),
        .high_water         (high_water),
        .counter_value      (counter_value)
    );

endmodule

[hdl/tcq_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the queue core and its bind
module tcq_checker #(
    parameter int QUEUE_DEPTH  = tcq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tcq_pkg::PAYLOAD_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [1:0]                       result_kind,
    input logic [PAYLOAD_BITS-1:0]          record_payload,
    input logic                             last,
    input logic                             accepted,
    input logic                             evicted_sample,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] high_water
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(record_payload) && $stable(last))
    else $error("stalled result changed");

    // every operation taken raises in_stall, so no two are taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == tcq_pkg::KIND_ACK) |-> occupancy <= high_water)
    else $error("occupancy above high-water mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_sample |-> accepted && (result_kind == tcq_pkg::KIND_ACK))
    else $error("eviction without admission");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == tcq_pkg::KIND_REC) |-> (occupancy == '0) && !accepted)
    else $error("drained record with nonzero occupancy or accept");

endmodule

bind two_class_drop_policy_queue_core tcq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_tcq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .record_payload (record_payload),
    .last           (last),
    .accepted       (accepted),
    .evicted_sample (evicted_sample),
    .occupancy      (occupancy),
    .high_water     (high_water)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the two-class drop-policy record queue core
module tb;
    import tcq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int PW    = PAYLOAD_BITS_DEF;
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic [1:0]          FUNC_SPARE    = 2'd3;
    localparam logic [SEL_BITS-1:0] SEL_UNUSED_LO = 3'd6;
    localparam logic [SEL_BITS-1:0] SEL_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic          cls;
        logic [PW-1:0] pay;
    } record_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                cls;
        logic [PW-1:0]       pay;
        logic                last_mark;
        logic                acc;
        logic                evict;
        logic                closed;
        logic [OCC_W-1:0]    occ;
        logic [OCC_W-1:0]    peak;
        logic [CNT_BITS-1:0] cnt;
    } outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           func;
    logic                 is_structural;
    logic [PW-1:0]        payload;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           result_kind;
    logic                 record_structural;
    logic [PW-1:0]        record_payload;
    logic                 last;
    logic                 accepted;
    logic                 evicted_sample;
    logic                 is_closed;
    logic [OCC_W-1:0]     occupancy;
    logic [OCC_W-1:0]     high_water;
    logic [CNT_BITS-1:0]  counter_value;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;

    two_class_drop_policy_queue_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .is_structural     (is_structural),
        .payload           (payload),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_kind       (result_kind),
        .record_structural (record_structural),
        .record_payload    (record_payload),
        .last              (last),
        .accepted          (accepted),
        .evicted_sample    (evicted_sample),
        .is_closed         (is_closed),
        .occupancy         (occupancy),
        .high_water        (high_water),
        .counter_value     (counter_value),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // shadow copy of the queue state and registers
    record_t             held[$];
    logic                sh_closed;
    int                  sh_peak;
    logic [CNT_BITS-1:0] sh_events [CNT_NUM];
    logic                sh_policy;
    logic [CAP_BITS-1:0] sh_cap;
    logic [CAP_BITS-1:0] sh_reserve;
    logic [SEL_BITS-1:0] sh_select;

    outcome_t due_results[$];
    outcome_t seen;
    outcome_t want;
    int       mismatch_count = 0;
    bit       tx_pause_on = 1'b0;
    bit       rx_pause_on = 1'b0;
    bit       hold_off_req = 1'b0;
    int       hold_off_len = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd30_000_000);
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void count_event(logic [SEL_BITS-1:0] idx);
        if (sh_events[idx] != '1)
            sh_events[idx]++;
    endfunction

    function automatic void post_outcome(logic [1:0] kind, logic cls, logic [PW-1:0] pay,
                                         logic last_mark, logic acc, logic evict);
        outcome_t o;
        o.kind      = kind;
        o.cls       = cls;
        o.pay       = pay;
        o.last_mark = last_mark;
        o.acc       = acc;
        o.evict     = evict;
        o.closed    = sh_closed;
        o.occ       = OCC_W'(held.size());
        o.peak      = OCC_W'(sh_peak);
        o.cnt       = (sh_select < CNT_NUM) ? sh_events[sh_select] : '0;
        due_results = {due_results, o};
    endfunction

    function automatic void predict_op(logic [1:0] f, logic cls, logic [PW-1:0] pay);
        int      limit;
        int      victim;
        int      i;
        logic    evicted;
        record_t rec;
        record_t snap[$];
        evicted = 1'b0;
        if (f == FUNC_CLOSE)
        begin
            sh_closed = 1'b1;
            return;
        end
        if (f == FUNC_DRAIN)
        begin
            if (held.size() == 0)
            begin
                post_outcome(KIND_EMPTY, 1'b0, '0, 1'b1, 1'b0, 1'b0);
                return;
            end
            // occupancy reads zero on every drained record
            snap = held;
            held.delete();
            foreach (snap[k])
                post_outcome(KIND_REC, snap[k].cls, snap[k].pay, k == snap.size() - 1,
                             1'b0, 1'b0);
            return;
        end
        if (f != FUNC_OFFER)
            return;
        if (sh_closed)
        begin
            count_event(cls ? CNT_STRU_LATE : CNT_SAMP_LATE);
            post_outcome(KIND_ACK, 1'b0, '0, 1'b1, 1'b0, 1'b0);
            return;
        end
        count_event(cls ? CNT_STRU_OFF : CNT_SAMP_OFF);
        limit = cls ? int'(sh_cap) + int'(sh_reserve) : int'(sh_cap);
        if (limit > DEPTH)
            limit = DEPTH;
        if (held.size() >= limit)
        begin
            // drop-oldest looks for the oldest sample, structural records are kept
            victim = -1;
            if (sh_policy)
                for (i = 0; i < held.size() && victim < 0; i++)
                    if (!held[i].cls)
                        victim = i;
            if (victim < 0)
            begin
                count_event(cls ? CNT_STRU_DROP : CNT_SAMP_DROP);
                post_outcome(KIND_ACK, 1'b0, '0, 1'b1, 1'b0, 1'b0);
                return;
            end
            count_event(CNT_SAMP_DROP);
            held.delete(victim);
            evicted = 1'b1;
        end
        rec.cls = cls;
        rec.pay = pay;
        held = {held, rec};
        if (held.size() > sh_peak)
            sh_peak = held.size();
        post_outcome(KIND_ACK, 1'b0, '0, 1'b1, 1'b1, evicted);
    endfunction

    function automatic string describe(outcome_t o);
        return $sformatf("kind=%0d cls=%0d pay=%h last=%0d acc=%0d evict=%0d closed=%0d %s",
                         o.kind, o.cls, o.pay, o.last_mark, o.acc, o.evict, o.closed,
                         $sformatf("occ=%0d hw=%0d cnt=%0d", o.occ, o.peak, o.cnt));
    endfunction

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // valid stays high after a transfer unless a gap follows
    task automatic send_item(logic [1:0] f, logic cls, logic [PW-1:0] pay);
        in_valid      <= 1'b1;
        func          <= f;
        is_structural <= cls;
        payload       <= pay;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_op(f, cls, pay);
        if (tx_pause_on)
            pause_sender(pick_gap());
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            send_item(FUNC_OFFER, ($urandom_range(99) < 40), $urandom);
        else if (r < 92)
            send_item(FUNC_DRAIN, 1'($urandom_range(1)), $urandom);
        else
            send_item(FUNC_SPARE, 1'($urandom_range(1)), $urandom);
    endtask

    // close and ignored ops give no result, so allow the sequencer time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DROP_POLICY: sh_policy  = val[0];
            REG_SAMPLE_CAP:  sh_cap     = val[CAP_BITS-1:0];
            REG_STRUCT_RES:  sh_reserve = val[CAP_BITS-1:0];
            REG_CNT_SELECT:  sh_select  = val[SEL_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(logic policy, logic [CAP_BITS-1:0] cap,
                             logic [CAP_BITS-1:0] res, logic [SEL_BITS-1:0] sel);
        wait_idle();
        write_reg(REG_DROP_POLICY, CFG_BITS'(policy));
        write_reg(REG_SAMPLE_CAP, CFG_BITS'(cap));
        write_reg(REG_STRUCT_RES, CFG_BITS'(res));
        write_reg(REG_CNT_SELECT, CFG_BITS'(sel));
    endtask

    task automatic test_reset_defaults();
        send_item(FUNC_OFFER, 1'b0, '0);
        send_item(FUNC_OFFER, 1'b1, '1);
        send_item(FUNC_SPARE, 1'b1, 32'h5555_5555);
        send_item(FUNC_DRAIN, 1'b0, 32'hAAAA_AAAA);
        send_item(FUNC_DRAIN, 1'b1, '0);
    endtask

    task automatic test_drop_newest();
        configure(1'b0, 7'd2, 7'd1, CNT_SAMP_DROP);
        send_item(FUNC_OFFER, 1'b0, 32'hAAAA_AAAA);
        send_item(FUNC_OFFER, 1'b0, 32'h5555_5555);
        send_item(FUNC_OFFER, 1'b0, '1);
        // structural record still fits in the reserve
        send_item(FUNC_OFFER, 1'b1, '0);
        send_item(FUNC_OFFER, 1'b1, '1);
        send_item(FUNC_DRAIN, 1'b0, '0);
    endtask

    task automatic test_drop_oldest();
        configure(1'b1, 7'd3, 7'd0, CNT_STRU_DROP);
        send_item(FUNC_OFFER, 1'b1, 32'h0000_0001);
        send_item(FUNC_OFFER, 1'b0, 32'h0000_0002);
        send_item(FUNC_OFFER, 1'b1, 32'h0000_0003);
        // evicts the sample in the middle, the record behind it moves up
        send_item(FUNC_OFFER, 1'b1, 32'h0000_0004);
        // only structural records left, so the sample is refused
        send_item(FUNC_OFFER, 1'b0, 32'h0000_0005);
        send_item(FUNC_DRAIN, 1'b0, '0);
        configure(1'b1, 7'd0, 7'd0, CNT_SAMP_DROP);
        send_item(FUNC_OFFER, 1'b0, '1);
        send_item(FUNC_OFFER, 1'b1, '1);
        send_item(FUNC_DRAIN, 1'b1, '0);
    endtask

    // limits clamp to the depth; receiver holds off while the sender offers with no gaps
    task automatic test_fill_under_backpressure();
        configure(1'($urandom_range(1)), 7'd127, 7'd127, CNT_STRU_OFF);
        tx_pause_on  = 1'b0;
        rx_pause_on  = 1'b0;
        hold_off_len = 150;
        hold_off_req = 1'b1;
        repeat (70)
            send_item(FUNC_OFFER, ($urandom_range(3) == 0), $urandom);
        send_item(FUNC_DRAIN, 1'b0, $urandom);
    endtask

    task automatic test_random_traffic();
        int                  r;
        logic [CAP_BITS-1:0] cap;
        logic [CAP_BITS-1:0] res;
        for (int ph = 0; ph < 5; ph++)
        begin
            r = $urandom_range(9);
            if (r < 7)
                cap = CAP_BITS'($urandom_range(6));
            else if (r == 7)
                cap = 7'd0;
            else if (r == 8)
                cap = 7'd64;
            else
                cap = 7'd127;
            res = ($urandom_range(4) == 0) ? 7'd64 : CAP_BITS'($urandom_range(3));
            configure(1'($urandom_range(1)), cap, res, SEL_BITS'($urandom_range(7)));
            tx_pause_on = ph[0];
            rx_pause_on = ph[1] | ph[2];
            repeat (16)
                random_item();
        end
    endtask

    // closing is final, so this runs last
    task automatic test_close_and_late_offers();
        configure(1'b0, 7'd4, 7'd2, CNT_SAMP_LATE);
        tx_pause_on = 1'b0;
        rx_pause_on = 1'b0;
        send_item(FUNC_OFFER, 1'b0, 32'h1234_5678);
        send_item(FUNC_OFFER, 1'b1, 32'h8765_4321);
        send_item(FUNC_CLOSE, 1'b0, '0);
        send_item(FUNC_SPARE, 1'b0, '0);
        send_item(FUNC_OFFER, 1'b0, '1);
        send_item(FUNC_OFFER, 1'b1, '0);
        send_item(FUNC_DRAIN, 1'b0, '0);
        send_item(FUNC_DRAIN, 1'b0, '0);
        configure(1'b0, 7'd4, 7'd2, CNT_STRU_LATE);
        send_item(FUNC_OFFER, 1'b1, 32'hFFFF_0000);
        configure(1'b1, 7'd4, 7'd2, SEL_UNUSED_LO);
        send_item(FUNC_OFFER, 1'b0, 32'h0000_FFFF);
        configure(1'b1, 7'd4, 7'd2, SEL_UNUSED_HI);
        send_item(FUNC_DRAIN, 1'b1, '1);
        configure(1'b1, 7'd4, 7'd2, CNT_SAMP_LATE);
        tx_pause_on = 1'b1;
        rx_pause_on = 1'b1;
        repeat (12)
            random_item();
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_pause_on)
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // every result transfer is matched against the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {result_kind, record_structural, record_payload, last, accepted,
                    evicted_sample, is_closed, occupancy, high_water, counter_value};
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("error: unexpected result %s", describe(seen));
            end
            else
            begin
                want = due_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("error: result mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(seen));
                end
            end
        end
    end

    initial
    begin
        in_valid      <= 1'b0;
        func          <= FUNC_OFFER;
        is_structural <= 1'b0;
        payload       <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_DROP_POLICY;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        sh_closed  = 1'b0;
        sh_peak    = 0;
        sh_policy  = RST_DROP_POLICY;
        sh_cap     = RST_SAMPLE_CAP;
        sh_reserve = RST_STRUCT_RES;
        sh_select  = RST_CNT_SELECT;
        foreach (sh_events[k])
            sh_events[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_drop_newest();
        test_drop_oldest();
        test_fill_under_backpressure();
        test_random_traffic();
        test_close_and_late_offers();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
hdl/tcq_pkg.sv
hdl/tcq_store.sv
hdl/tcq_counters.sv
hdl/tcq_ctrl.sv
hdl/two_class_drop_policy_queue_core.sv
hdl/tcq_checker.sv
tb/tb.sv
